// ----- hw/rtl/sra_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sra_pkg: shared types and constants for the shelf rectangle allocator
// Field widths, register codes and the control/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package sra_pkg;

    localparam int W_COORD   = 13;  // coordinates, sizes and registers
    localparam int W_REQ     = 16;  // requested sizes
    localparam int W_CFG_IDX = 2;   // register index on the config channel

    localparam int SRA_MAX_SHELVES_DEF = 32;

    localparam logic [W_COORD-1:0] ATLAS_LIMIT = W_COORD'(4096);

    // register indexes
    localparam logic [W_CFG_IDX-1:0] CFG_ATLAS_WIDTH  = W_CFG_IDX'(0);
    localparam logic [W_CFG_IDX-1:0] CFG_ATLAS_HEIGHT = W_CFG_IDX'(1);

    // request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic [W_COORD-1:0] top;
        logic [W_COORD-1:0] tall;
        logic [W_COORD-1:0] cursor;
    } t_shelf;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture the request
        logic scan;    // issue next shelf read
        logic fit;     // place on the shelf just read
        logic open;    // open a new shelf
        logic fail;    // refused, no room or clear: zero placement
        logic clear;   // empty shelf table and bounds
        logic bound;   // grow bounding box
        logic emit;    // load the result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_clear;
        logic refuse;
        logic empty;
        logic rd_valid;
        logic hit;
        logic last;
        logic full;
        logic open_fits;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ----- hw/rtl/sra_channels.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sra_channels: handshake channels of the shelf rectangle allocator
// Request, result and register-write channels, each valid/ready.
// ----------------------------------------------------------------------------
interface sra_req_if import sra_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             op;
    logic [W_REQ-1:0] req_width;
    logic [W_REQ-1:0] req_height;

    modport source (output valid, op, req_width, req_height, input ready);
    modport sink   (input valid, op, req_width, req_height, output ready);
endinterface

interface sra_rsp_if import sra_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               ok;
    logic [W_COORD-1:0] place_x;
    logic [W_COORD-1:0] place_y;
    logic [W_COORD-1:0] place_width;
    logic [W_COORD-1:0] place_height;
    logic [W_COORD-1:0] used_x;
    logic [W_COORD-1:0] used_y;
    logic [W_COORD-1:0] used_width;
    logic [W_COORD-1:0] used_height;

    modport source (output valid, ok, place_x, place_y, place_width, place_height,
                    used_x, used_y, used_width, used_height, input ready);
    modport sink   (input valid, ok, place_x, place_y, place_width, place_height,
                    used_x, used_y, used_width, used_height, output ready);
endinterface

interface sra_cfg_if import sra_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [W_CFG_IDX-1:0] idx;
    logic [W_COORD-1:0]   data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/shelf_rect_allocator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shelf_rect_allocator_core: first-fit shelf packer for a texture atlas
// Places rectangles on shelves, opens new shelves below the last one,
// and reports the bounding box of used space with every result.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+-----------
//  i_req    | in  | op, req_width, req_height                 | valid/ready
//  o_rsp    | out | ok, place_x/y/width/height, used_x/y/w/h  | valid/ready
//  i_cfg    | in  | idx (0 atlas_width, 1 atlas_height), data | valid/ready
//
//  Steps: check, then the scan reads one shelf a cycle through the
//  table's single registered read port. A hit on a shelf goes to fit,
//  bound and emit; no hit (or no shelves) goes to open, then bound and
//  emit, or to emit if there is no room; clear or refused at the check: emit.
//  Reset (synchronous, active low) empties the shelf count and bounds and
//  sets both atlas registers to 4096; shelf entries are not cleared.
//  Stalls: the result register holds a finished result while o_rsp is held
//  off, and a new request is taken meanwhile; it completes once the
//  register is free. Config writes are always ready.
//
module shelf_rect_allocator_core import sra_pkg::*; #(
    parameter int MAX_SHELVES = SRA_MAX_SHELVES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sra_req_if.sink     i_req,
    sra_rsp_if.source   o_rsp,
    sra_cfg_if.sink     i_cfg
);

    // controller <-> datapath
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    // request ready comes from the sequencer, payload lands in the datapath
    assign i_req.ready = w_in_ready;

    sra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sra_dp #(
        .MAX_SHELVES (MAX_SHELVES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (i_cfg),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/sra_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sra_ctrl: sequencer for the shelf rectangle allocator
// One request at a time: check, scan shelves, place or open, bound, emit.
// ----------------------------------------------------------------------------
module sra_ctrl import sra_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_FIT   = 7'b0001000,
        S_OPEN  = 7'b0010000,
        S_BOUND = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_sts.is_clear) begin
                    o_cmd.clear = 1'b1;
                    o_cmd.fail  = 1'b1;
                    n_state     = S_EMIT;
                end else if (i_sts.refuse) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_EMIT;
                end else if (i_sts.empty) begin
                    n_state = S_OPEN;
                end else begin
                    o_cmd.scan = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // no further read once a shelf hits: the read data must
                // still hold that shelf in S_FIT
                priority if (i_sts.rd_valid && i_sts.hit) begin
                    n_state = S_FIT;
                end else if (i_sts.rd_valid && i_sts.last) begin
                    n_state = S_OPEN;
                end else begin
                    o_cmd.scan = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_FIT: begin
                o_cmd.fit = 1'b1;
                n_state   = S_BOUND;
            end
            S_OPEN: begin
                if (!i_sts.full && i_sts.open_fits) begin
                    o_cmd.open = 1'b1;
                    n_state    = S_BOUND;
                end else begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_EMIT;
                end
            end
            S_BOUND: begin
                o_cmd.bound = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sra_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sra_dp: datapath of the shelf rectangle allocator
// Atlas registers, shelf table memory, scan read pipe, bounding box and
// the result register.
// ----------------------------------------------------------------------------
module sra_dp import sra_pkg::*; #(
    parameter int MAX_SHELVES = SRA_MAX_SHELVES_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    sra_req_if.sink         i_req,
    sra_rsp_if.source       o_rsp,
    sra_cfg_if.sink         i_cfg,
    input  t_cmd            i_cmd,
    output t_sts            o_sts
);

    localparam int AW = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
    localparam int CW = $clog2(MAX_SHELVES + 1);

    // atlas size
    logic [W_COORD-1:0] r_aw;
    logic [W_COORD-1:0] r_ah;
    logic [W_COORD-1:0] w_cfg_sat;

    // captured request
    logic               r_op;
    logic [W_REQ-1:0]   r_w;
    logic [W_REQ-1:0]   r_h;
    logic [W_COORD-1:0] w_w13;
    logic [W_COORD-1:0] w_h13;

    // shelf table
    t_shelf             r_mem [MAX_SHELVES];
    logic [CW-1:0]      r_count;
    logic [W_COORD-1:0] r_next_top;
    logic [CW-1:0]      r_idx;
    logic               r_rd_valid;
    logic [AW-1:0]      r_rd_idx;
    t_shelf             r_rd_data;
    logic               w_rd_en;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    t_shelf             w_wdata;

    // placement and bounds
    logic               r_ok;
    logic [W_COORD-1:0] r_px;
    logic [W_COORD-1:0] r_py;
    logic [W_COORD-1:0] r_bx;
    logic [W_COORD-1:0] r_by;
    logic [W_COORD-1:0] r_bw;
    logic [W_COORD-1:0] r_bh;
    logic [W_COORD-1:0] w_lx;
    logic [W_COORD-1:0] w_ly;
    logic [W_COORD:0]   w_hx;
    logic [W_COORD:0]   w_hy;
    logic [W_COORD:0]   w_bxe;
    logic [W_COORD:0]   w_bye;
    logic [W_COORD:0]   w_pxe;
    logic [W_COORD:0]   w_pye;

    // result register
    logic               r_out_valid;
    logic               r_out_ok;
    logic [W_COORD-1:0] r_out_px;
    logic [W_COORD-1:0] r_out_py;
    logic [W_COORD-1:0] r_out_pw;
    logic [W_COORD-1:0] r_out_ph;
    logic [W_COORD-1:0] r_out_bx;
    logic [W_COORD-1:0] r_out_by;
    logic [W_COORD-1:0] r_out_bw;
    logic [W_COORD-1:0] r_out_bh;

    // --- config ---
    assign i_cfg.ready = 1'b1;
    assign w_cfg_sat   = (i_cfg.data > ATLAS_LIMIT) ? ATLAS_LIMIT : i_cfg.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aw <= ATLAS_LIMIT;
            r_ah <= ATLAS_LIMIT;
        end else if (i_cfg.valid) begin
            if (i_cfg.idx == CFG_ATLAS_WIDTH) begin
                r_aw <= w_cfg_sat;
            end
            if (i_cfg.idx == CFG_ATLAS_HEIGHT) begin
                r_ah <= w_cfg_sat;
            end
        end
    end

    // --- request capture ---
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_req.op;
            r_w  <= i_req.req_width;
            r_h  <= i_req.req_height;
        end
    end

    // sizes fit 13 bits once past the refusal check
    assign w_w13 = r_w[W_COORD-1:0];
    assign w_h13 = r_h[W_COORD-1:0];

    // --- shelf table ---
    assign w_rd_en = i_cmd.scan && (r_idx < r_count);
    assign w_we    = i_cmd.fit || i_cmd.open;
    assign w_waddr = i_cmd.fit ? r_rd_idx : r_count[AW-1:0];

    always_comb begin
        if (i_cmd.fit) begin
            w_wdata        = r_rd_data;
            w_wdata.cursor = r_rd_data.cursor + w_w13;
        end else begin
            w_wdata.top    = r_next_top;
            w_wdata.tall   = w_h13;
            w_wdata.cursor = w_w13;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
            r_rd_idx  <= r_idx[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_next_top <= '0;
            r_idx      <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= w_rd_en;
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (w_rd_en) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.clear) begin
                r_count    <= '0;
                r_next_top <= '0;
            end else if (i_cmd.open) begin
                r_count    <= r_count + CW'(1);
                r_next_top <= r_next_top + w_h13;
            end
        end
    end

    // --- placement ---
    always_ff @(posedge i_clk) begin
        if (i_cmd.fail) begin
            r_ok <= 1'b0;
            r_px <= '0;
            r_py <= '0;
        end else if (i_cmd.fit) begin
            r_ok <= 1'b1;
            r_px <= r_rd_data.cursor;
            r_py <= r_rd_data.top;
        end else if (i_cmd.open) begin
            r_ok <= 1'b1;
            r_px <= '0;
            r_py <= r_next_top;
        end
    end

    // --- bounding box ---
    assign w_lx  = (r_bx < r_px) ? r_bx : r_px;
    assign w_ly  = (r_by < r_py) ? r_by : r_py;
    assign w_bxe = {1'b0, r_bx} + {1'b0, r_bw};
    assign w_bye = {1'b0, r_by} + {1'b0, r_bh};
    assign w_pxe = {1'b0, r_px} + {1'b0, w_w13};
    assign w_pye = {1'b0, r_py} + {1'b0, w_h13};
    assign w_hx  = (w_pxe > w_bxe) ? w_pxe : w_bxe;
    assign w_hy  = (w_pye > w_bye) ? w_pye : w_bye;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bx <= '0;
            r_by <= '0;
            r_bw <= '0;
            r_bh <= '0;
        end else if (i_cmd.clear) begin
            r_bx <= '0;
            r_by <= '0;
            r_bw <= '0;
            r_bh <= '0;
        end else if (i_cmd.bound) begin
            if (r_bw == '0) begin
                r_bx <= r_px;
                r_by <= r_py;
                r_bw <= w_w13;
                r_bh <= w_h13;
            end else begin
                r_bx <= w_lx;
                r_by <= w_ly;
                r_bw <= W_COORD'(w_hx - {1'b0, w_lx});
                r_bh <= W_COORD'(w_hy - {1'b0, w_ly});
            end
        end
    end

    // --- result register ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_ok <= r_ok;
            r_out_px <= r_px;
            r_out_py <= r_py;
            r_out_pw <= r_ok ? w_w13 : '0;
            r_out_ph <= r_ok ? w_h13 : '0;
            r_out_bx <= r_bx;
            r_out_by <= r_by;
            r_out_bw <= r_bw;
            r_out_bh <= r_bh;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.ok           = r_out_ok;
    assign o_rsp.place_x      = r_out_px;
    assign o_rsp.place_y      = r_out_py;
    assign o_rsp.place_width  = r_out_pw;
    assign o_rsp.place_height = r_out_ph;
    assign o_rsp.used_x       = r_out_bx;
    assign o_rsp.used_y       = r_out_by;
    assign o_rsp.used_width   = r_out_bw;
    assign o_rsp.used_height  = r_out_bh;

    // --- status ---
    assign o_sts.is_clear  = (r_op == OP_CLEAR);
    assign o_sts.refuse    = (r_w == '0) || (r_h == '0)
                          || (r_w > {{(W_REQ-W_COORD){1'b0}}, r_aw})
                          || (r_h > {{(W_REQ-W_COORD){1'b0}}, r_ah});
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.rd_valid  = r_rd_valid;
    assign o_sts.hit       = (r_rd_data.tall >= w_h13)
                          && (({1'b0, r_rd_data.cursor} + {1'b0, w_w13}) <= {1'b0, r_aw});
    assign o_sts.last      = ((CW'(r_rd_idx) + CW'(1)) == r_count);
    assign o_sts.full      = (r_count == CW'(MAX_SHELVES));
    assign o_sts.open_fits = (({1'b0, r_next_top} + {1'b0, w_h13}) <= {1'b0, r_ah});
    assign o_sts.out_free  = !r_out_valid || o_rsp.ready;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SHELVES))
        else $error("shelf count past table depth");

    a_open_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.open && !i_cmd.clear |=> r_count == CW'($past(r_count) + CW'(1)))
        else $error("new shelf did not bump count");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> r_count == '0 && r_bw == '0 && r_bh == '0)
        else $error("clear left shelves or bounds");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("result not presented after emit");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_out_valid || o_rsp.ready)
        else $error("result overwritten before taken");
`endif

endmodule
`default_nettype wire

// ----- tb/sra_placement_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sra_placement_checker: result prediction and comparison for the allocator
// Watches the request, result and register channels, keeps its own shelf
// table and bounding box, and checks every result against the prediction.
// ----------------------------------------------------------------------------
module sra_placement_checker import sra_pkg::*; #(
    parameter int MAX_SHELVES = SRA_MAX_SHELVES_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    sra_req_if   i_req,
    sra_rsp_if   i_rsp,
    sra_cfg_if   i_cfg,
    output int   o_fault_count,
    output int   o_placements_due
);

    typedef struct packed {
        logic               ok;
        logic [W_COORD-1:0] place_x;
        logic [W_COORD-1:0] place_y;
        logic [W_COORD-1:0] place_width;
        logic [W_COORD-1:0] place_height;
        logic [W_COORD-1:0] used_x;
        logic [W_COORD-1:0] used_y;
        logic [W_COORD-1:0] used_width;
        logic [W_COORD-1:0] used_height;
    } placement_t;

    logic [W_COORD-1:0] atlas_w;
    logic [W_COORD-1:0] atlas_h;
    logic [W_COORD-1:0] row_top    [MAX_SHELVES];
    logic [W_COORD-1:0] row_tall   [MAX_SHELVES];
    logic [W_COORD-1:0] row_cursor [MAX_SHELVES];
    int unsigned        row_count;
    int unsigned        box_x, box_y, box_w, box_h;

    placement_t placements_due[$];

    // first-fit placement on the mirrored shelf table
    task automatic pack_rect(input logic op, input logic [W_REQ-1:0] req_w,
                             input logic [W_REQ-1:0] req_h, output placement_t res);
        int unsigned w, h, px, py, ny, lx, ly, hx, hy;
        bit          placed;
        int unsigned i;
        w      = req_w;
        h      = req_h;
        px     = 0;
        py     = 0;
        placed = 1'b0;
        if (op == OP_CLEAR) begin
            row_count = 0;
            box_x = 0;
            box_y = 0;
            box_w = 0;
            box_h = 0;
        end else if (w != 0 && h != 0 && w <= atlas_w && h <= atlas_h) begin
            for (i = 0; i < row_count; i++) begin
                if (!placed && row_tall[i] >= h && row_cursor[i] + w <= atlas_w) begin
                    px            = row_cursor[i];
                    py            = row_top[i];
                    row_cursor[i] = W_COORD'(row_cursor[i] + w);
                    placed        = 1'b1;
                end
            end
            if (!placed && row_count < MAX_SHELVES) begin
                ny = 0;
                if (row_count > 0)
                    ny = row_top[row_count-1] + row_tall[row_count-1];
                if (ny + h <= atlas_h) begin
                    row_top[row_count]    = W_COORD'(ny);
                    row_tall[row_count]   = W_COORD'(h);
                    row_cursor[row_count] = W_COORD'(w);
                    row_count++;
                    px     = 0;
                    py     = ny;
                    placed = 1'b1;
                end
            end
            if (placed) begin
                if (box_w == 0) begin
                    box_x = px;
                    box_y = py;
                    box_w = w;
                    box_h = h;
                end else begin
                    lx = (box_x < px) ? box_x : px;
                    ly = (box_y < py) ? box_y : py;
                    hx = (px + w > box_x + box_w) ? px + w : box_x + box_w;
                    hy = (py + h > box_y + box_h) ? py + h : box_y + box_h;
                    box_x = lx;
                    box_y = ly;
                    box_w = hx - lx;
                    box_h = hy - ly;
                end
            end
        end
        res.ok           = placed;
        res.place_x      = W_COORD'(px);
        res.place_y      = W_COORD'(py);
        res.place_width  = placed ? W_COORD'(w) : '0;
        res.place_height = placed ? W_COORD'(h) : '0;
        res.used_x       = W_COORD'(box_x);
        res.used_y       = W_COORD'(box_y);
        res.used_width   = W_COORD'(box_w);
        res.used_height  = W_COORD'(box_h);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fault_count++;
        end
    endtask

    initial begin
        o_fault_count    = 0;
        o_placements_due = 0;
    end

    always @(posedge i_clk) begin : watch
        logic [W_COORD-1:0] reg_val;
        placement_t         due;
        placement_t         res;
        if (!i_rst_n) begin
            atlas_w   = ATLAS_LIMIT;
            atlas_h   = ATLAS_LIMIT;
            row_count = 0;
            box_x     = 0;
            box_y     = 0;
            box_w     = 0;
            box_h     = 0;
            placements_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                reg_val = (i_cfg.data > ATLAS_LIMIT) ? ATLAS_LIMIT : i_cfg.data;
                if (i_cfg.idx == CFG_ATLAS_WIDTH)
                    atlas_w = reg_val;
                else if (i_cfg.idx == CFG_ATLAS_HEIGHT)
                    atlas_h = reg_val;
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (placements_due.size() == 0) begin
                    $error("result with no request outstanding");
                    o_fault_count++;
                end else begin
                    due = placements_due.pop_front();
                    check_field("ok",           due.ok,           i_rsp.ok);
                    check_field("place_x",      due.place_x,      i_rsp.place_x);
                    check_field("place_y",      due.place_y,      i_rsp.place_y);
                    check_field("place_width",  due.place_width,  i_rsp.place_width);
                    check_field("place_height", due.place_height, i_rsp.place_height);
                    check_field("used_x",       due.used_x,       i_rsp.used_x);
                    check_field("used_y",       due.used_y,       i_rsp.used_y);
                    check_field("used_width",   due.used_width,   i_rsp.used_width);
                    check_field("used_height",  due.used_height,  i_rsp.used_height);
                end
            end
            if (i_req.valid && i_req.ready) begin
                pack_rect(i_req.op, i_req.req_width, i_req.req_height, res);
                placements_due = {placements_due, res};
            end
        end
        o_placements_due = placements_due.size();
    end

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for shelf_rect_allocator_core
// Directed corner requests, then random packing sessions over a range of
// atlas sizes, with random sender gaps and result stalls. Checking is done
// by sra_placement_checker, which sits beside the block.
// ----------------------------------------------------------------------------
module tb;
    import sra_pkg::*;

    localparam int REQUEST_TARGET = 650;
    // from here on neither side idles
    localparam int CALM_AFTER     = 560;

    // indexes the block does not decode; writes to them must be ignored
    localparam logic [W_CFG_IDX-1:0] CFG_SPARE_LO = W_CFG_IDX'(2);
    localparam logic [W_CFG_IDX-1:0] CFG_SPARE_HI = W_CFG_IDX'(3);

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sra_req_if req_ch();
    sra_rsp_if rsp_ch();
    sra_cfg_if cfg_ch();

    int fault_count;
    int due_count;

    int requests_sent = 0;
    bit calm          = 1'b0;
    int gap_pct       = 30;   // chance of a sender gap after each request
    int stall_pct     = 25;   // chance of a result stall starting
    int stall_left    = 0;

    // atlas size as last written, saturated as the block does it
    int unsigned cur_w = ATLAS_LIMIT;
    int unsigned cur_h = ATLAS_LIMIT;

    always #1 i_clk = ~i_clk;

    shelf_rect_allocator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    sra_placement_checker #(.MAX_SHELVES(SRA_MAX_SHELVES_DEF)) checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (req_ch),
        .i_rsp            (rsp_ch),
        .i_cfg            (cfg_ch),
        .o_fault_count    (fault_count),
        .o_placements_due (due_count)
    );

    // Result back-pressure: ready drops in bursts counted down in stall_left. One
    // nonblocking write per falling edge, so no glitch within a step.
    always @(negedge i_clk) begin
        if (calm) begin
            rsp_ch.ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 5);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Present one request and hold it until taken. Valid is left high
    // afterwards so back-to-back requests go out without a drop in valid; every path
    // that stops sending lowers it first.
    task automatic send_req(input logic op, input logic [W_REQ-1:0] w,
                            input logic [W_REQ-1:0] h);
        int n;
        @(negedge i_clk);
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.req_width  <= w;
        req_ch.req_height <= h;
        do @(posedge i_clk); while (!req_ch.ready);
        requests_sent++;
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                @(negedge i_clk);
                req_ch.valid <= 1'b0;
            end
        end
    endtask

    // Stop sending and wait until every outstanding request has its result.
    // Every request yields exactly one result, so the block is idle then.
    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (due_count != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [W_CFG_IDX-1:0] idx,
                             input logic [W_COORD-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx   <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Atlas extent: mostly small so shelves fill up, plus the extremes,
    // zero, and values past the limit that must saturate.
    function automatic int unsigned pick_extent();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return ATLAS_LIMIT;
        if (roll < 25) return 1;
        if (roll < 50) return $urandom_range(2, 16);
        if (roll < 75) return $urandom_range(17, 256);
        if (roll < 90) return $urandom_range(1, ATLAS_LIMIT);
        if (roll < 95) return 0;
        return $urandom_range(ATLAS_LIMIT + 1, 8191);
    endfunction

    // Requested size against the current extent: mostly fitting, small
    // sizes favoured, some exact fits, just-too-big and zero.
    function automatic logic [W_REQ-1:0] pick_size(input int unsigned limit);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (limit == 0) return W_REQ'($urandom_range(0, 3));
        if (roll < 55) return W_REQ'($urandom_range(1, (limit < 16) ? limit : 16));
        if (roll < 85) return W_REQ'($urandom_range(1, limit));
        if (roll < 93) return W_REQ'(limit);
        if (roll < 97) return W_REQ'(limit + 1);
        return '0;
    endfunction

    initial begin
        int          run_len;
        int          roll;
        bit          stacking;
        int unsigned v;

        req_ch.valid      = 1'b0;
        req_ch.op         = OP_ALLOC;
        req_ch.req_width  = '0;
        req_ch.req_height = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.idx        = CFG_ATLAS_WIDTH;
        cfg_ch.data       = '0;
        rsp_ch.ready      = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed: reset atlas is 4096 x 4096 ----
        // refusals: zero sizes and oversize in either dimension
        send_req(OP_ALLOC, 0, 5);
        send_req(OP_ALLOC, 5, 0);
        send_req(OP_ALLOC, 4097, 10);
        send_req(OP_ALLOC, 10, 16'hFFFF);
        send_req(OP_ALLOC, 16'hFFFF, 16'hFFFF);
        // full-width shelf, then a second shelf shared by two requests
        send_req(OP_ALLOC, 4096, 1);
        send_req(OP_ALLOC, 1, 1);
        send_req(OP_ALLOC, 100, 1);
        // tall shelf reaching the bottom edge exactly
        send_req(OP_ALLOC, 4095, 4094);
        // no room on any shelf and no height left for a new one
        send_req(OP_ALLOC, 10, 5);
        // last column of the tall shelf, cursor ends on the right edge
        send_req(OP_ALLOC, 1, 4000);
        // clear with all payload bits set, then the whole atlas at once
        send_req(OP_CLEAR, 16'hFFFF, 16'hFFFF);
        send_req(OP_ALLOC, 4096, 4096);
        send_req(OP_ALLOC, 1, 1);
        send_req(OP_CLEAR, 0, 0);

        // zero width register refuses everything
        drain();
        write_reg(CFG_ATLAS_WIDTH, 0);
        send_req(OP_ALLOC, 1, 1);

        // over-limit writes saturate; undecoded indexes are ignored
        drain();
        write_reg(CFG_ATLAS_WIDTH, 13'h1FFF);
        write_reg(CFG_ATLAS_HEIGHT, 5000);
        write_reg(CFG_SPARE_LO, 7);
        write_reg(CFG_SPARE_HI, 13'h1FFF);
        send_req(OP_ALLOC, 3, 2);
        send_req(OP_ALLOC, 2, 7);

        // shrink the height under existing shelves: old shelves still
        // take requests, no new shelf may open
        drain();
        write_reg(CFG_ATLAS_HEIGHT, 1);
        send_req(OP_ALLOC, 1, 1);
        send_req(OP_ALLOC, 5, 2);
        send_req(OP_ALLOC, 4096, 1);

        drain();
        write_reg(CFG_ATLAS_WIDTH, ATLAS_LIMIT);
        write_reg(CFG_ATLAS_HEIGHT, ATLAS_LIMIT);
        cur_w = ATLAS_LIMIT;
        cur_h = ATLAS_LIMIT;

        // ---- random packing sessions ----
        // Each session waits for the block to go idle (this is also where
        // the sender holds off until all results are in), may change the
        // atlas, usually clears, then sends a run of mostly well-formed
        // requests with some junk and stray clears mixed in.
        while (requests_sent < REQUEST_TARGET) begin
            drain();
            if (requests_sent >= CALM_AFTER)
                calm = 1'b1;
            gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 30;
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;

            if ($urandom_range(0, 99) < 60) begin
                v = pick_extent();
                write_reg(CFG_ATLAS_WIDTH, W_COORD'(v));
                cur_w = (v > ATLAS_LIMIT) ? ATLAS_LIMIT : v;
            end
            if ($urandom_range(0, 99) < 60) begin
                v = pick_extent();
                write_reg(CFG_ATLAS_HEIGHT, W_COORD'(v));
                cur_h = (v > ATLAS_LIMIT) ? ATLAS_LIMIT : v;
            end
            if ($urandom_range(0, 99) < 10)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                          W_COORD'($urandom));

            // stacking: narrow, full-height atlas and full-width requests,
            // so each full-width request needs a new shelf and the table runs out
            stacking = ($urandom_range(0, 99) < 15);
            if (stacking) begin
                cur_w = $urandom_range(1, 8);
                cur_h = ATLAS_LIMIT;
                write_reg(CFG_ATLAS_WIDTH, W_COORD'(cur_w));
                write_reg(CFG_ATLAS_HEIGHT, W_COORD'(cur_h));
            end

            // a session without a clear keeps old shelves under a new size
            if ($urandom_range(0, 99) < 80)
                send_req(OP_CLEAR, W_REQ'($urandom), W_REQ'($urandom));

            run_len = stacking ? $urandom_range(36, 44) : $urandom_range(8, 40);
            repeat (run_len) begin
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    send_req(OP_CLEAR, W_REQ'($urandom), W_REQ'($urandom));
                else if (roll < 12)
                    send_req(OP_ALLOC, W_REQ'($urandom), W_REQ'($urandom));
                else if (stacking)
                    send_req(OP_ALLOC, W_REQ'(cur_w), W_REQ'($urandom_range(1, 8)));
                else
                    send_req(OP_ALLOC, pick_size(cur_w), pick_size(cur_h));
            end
        end

        drain();
        // wait on after the drain so any stray result shows up before the verdict
        repeat (100) @(posedge i_clk);
        if (fault_count == 0 && due_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: ends the run as failed if it still goes on after 1 ms, well
    // past the slowest correct run of ~700 requests with gaps and stalls.
    initial begin
        #1000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ----- shelf_rect_allocator_core.f -----
hw/rtl/sra_pkg.sv
hw/rtl/sra_channels.sv
hw/rtl/sra_ctrl.sv
hw/rtl/sra_dp.sv
hw/rtl/shelf_rect_allocator_core.sv
tb/sra_placement_checker.sv
tb/tb.sv
